// ===== hw/rtl/rlt_pkg.sv =====
`timescale 1ns / 1ps

package rlt_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned SumW    = 37;
  // a squared halved sample never exceeds 2^28
  localparam int unsigned SqW     = 30;
  // the mean of the squares fits in 29 bits
  localparam int unsigned QuoW    = 29;
  localparam int unsigned RootW   = 16;
  localparam int unsigned SmAccW  = 18;

  localparam logic [LevelW-1:0] WKeep          = 16'd60948;
  localparam logic [LevelW-1:0] WNew           = 16'd4588;
  localparam logic [LevelW-1:0] RoundHalf      = 16'd32768;
  localparam logic [LevelW-1:0] ThresholdReset = 16'd16384;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_LOAD,
    S_DIVIDE,
    S_ROOT,
    S_SMOOTH,
    S_EMIT
  } state_e;

endpackage

// ===== hw/rtl/rlt_square.sv =====
`timescale 1ns / 1ps

// Bit-serial squarer: |s| * |s| one multiplier bit per cycle, then drop two bits.
module rlt_square (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [rlt_pkg::SampleW-1:0] sample_i,
  output logic [rlt_pkg::SqW-1:0]        sq_o,
  output logic                           done_o
);

  localparam int unsigned StepW = $clog2(rlt_pkg::SampleW);
  localparam logic [StepW-1:0] LastStep = StepW'(rlt_pkg::SampleW - 1);

  logic [rlt_pkg::SampleW-1:0]   mag;
  logic [rlt_pkg::SampleW-1:0]   mcand_q, mcand_d;
  logic [rlt_pkg::SampleW-1:0]   mplier_q, mplier_d;
  logic [2*rlt_pkg::SampleW-1:0] prod_q, prod_d;
  logic [rlt_pkg::SampleW:0]     part_sum;
  logic [StepW-1:0]              step_q, step_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  // the most negative sample wraps to 0x8000, which reads correctly as unsigned
  assign mag = sample_i[rlt_pkg::SampleW-1] ? rlt_pkg::SampleW'(-sample_i)
                                           : rlt_pkg::SampleW'(sample_i);

  assign part_sum = {1'b0, prod_q[2*rlt_pkg::SampleW-1:rlt_pkg::SampleW]}
                  + (mplier_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    prod_d   = prod_q;
    step_d   = step_q;
    busy_d   = busy_q;
    done_d   = done_q;
    if (start_i) begin
      mcand_d  = mag;
      mplier_d = mag;
      prod_d   = '0;
      step_d   = '0;
      busy_d   = 1'b1;
      done_d   = 1'b0;
    end else if (busy_q) begin
      prod_d   = {part_sum, prod_q[rlt_pkg::SampleW-1:1]};
      mplier_d = mplier_q >> 1;
      step_d   = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    prod_q   <= prod_d;
  end

  assign sq_o   = prod_q[2*rlt_pkg::SampleW-1:2];
  assign done_o = done_q;

endmodule

// ===== hw/rtl/rlt_divide.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The upper dividend bits are
// below the divisor, so only the low quotient bits are developed.
module rlt_divide #(
  parameter int unsigned CntW = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rlt_pkg::SumW-1:0]  dividend_i,
  input  logic [CntW-1:0]           divisor_i,
  output logic [rlt_pkg::QuoW-1:0]  quo_o,
  output logic                      done_o
);

  localparam int unsigned StepW = $clog2(rlt_pkg::QuoW);
  localparam logic [StepW-1:0] LastStep = StepW'(rlt_pkg::QuoW - 1);

  logic [rlt_pkg::SumW-1:0] high_part;
  logic [CntW-1:0]          rem_q, rem_d;
  logic [CntW-1:0]          dvs_q, dvs_d;
  logic [rlt_pkg::QuoW-1:0] quo_q, quo_d;
  logic [CntW:0]            trial;
  logic [CntW:0]            diff;
  logic                     fits;
  logic [StepW-1:0]         step_q, step_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;

  assign high_part = dividend_i >> rlt_pkg::QuoW;
  assign trial     = {rem_q, quo_q[rlt_pkg::QuoW-1]};
  assign fits      = (trial >= {1'b0, dvs_q});
  assign diff      = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = high_part[CntW-1:0];
      dvs_d  = divisor_i;
      quo_d  = dividend_i[rlt_pkg::QuoW-1:0];
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      // shift the next dividend bit out, the quotient bit in
      rem_d  = fits ? diff[CntW-1:0] : trial[CntW-1:0];
      quo_d  = {quo_q[rlt_pkg::QuoW-2:0], fits};
      step_d = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/rlt_root.sv =====
`timescale 1ns / 1ps

// Digit-by-digit square root of 4*mean, two radicand bits per cycle.
module rlt_root (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rlt_pkg::QuoW-1:0]  mean_i,
  output logic [rlt_pkg::RootW-1:0] root_o,
  output logic                      done_o
);

  localparam int unsigned RadW  = 2 * rlt_pkg::RootW;
  localparam int unsigned RemW  = rlt_pkg::RootW + 1;
  localparam int unsigned StepW = $clog2(rlt_pkg::RootW);
  localparam logic [StepW-1:0] LastStep = StepW'(rlt_pkg::RootW - 1);

  logic [RadW-1:0]          rad_q, rad_d;
  logic [RemW-1:0]          rem_q, rem_d;
  logic [rlt_pkg::RootW-1:0] root_q, root_d;
  logic [RemW+1:0]          cand;
  logic [RemW+1:0]          trial;
  logic [RemW+1:0]          diff;
  logic                     fits;
  logic [StepW-1:0]         step_q, step_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;

  assign cand  = {rem_q, rad_q[RadW-1:RadW-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = (cand >= trial);
  assign diff  = cand - trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rad_d  = {1'b0, mean_i, 2'b00};
      rem_d  = '0;
      root_d = '0;
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      // the partial remainder stays at most twice the partial root
      rem_d  = fits ? diff[RemW-1:0] : cand[RemW-1:0];
      root_d = {root_q[rlt_pkg::RootW-2:0], fits};
      rad_d  = rad_q << 2;
      step_d = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/rlt_smooth.sv =====
`timescale 1ns / 1ps

// Bit-serial weighted sum (level*0.93 + rms*0.07, rounded half up).
// Each cycle add the weights for one bit of each operand, then halve.
module rlt_smooth (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rlt_pkg::LevelW-1:0] level_i,
  input  logic [rlt_pkg::RootW-1:0]  rms_i,
  output logic [rlt_pkg::LevelW-1:0] level_o,
  output logic                       done_o
);

  localparam int unsigned StepW = $clog2(rlt_pkg::LevelW);
  localparam logic [StepW-1:0] LastStep = StepW'(rlt_pkg::LevelW - 1);

  logic [rlt_pkg::LevelW-1:0] lvl_q, lvl_d;
  logic [rlt_pkg::RootW-1:0]  rms_q, rms_d;
  logic [rlt_pkg::SmAccW-1:0] acc_q, acc_d;
  logic [rlt_pkg::SmAccW-1:0] total;
  logic [StepW-1:0]           step_q, step_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  assign total = acc_q
               + (lvl_q[0] ? rlt_pkg::SmAccW'(rlt_pkg::WKeep) : '0)
               + (rms_q[0] ? rlt_pkg::SmAccW'(rlt_pkg::WNew) : '0);

  always_comb begin
    lvl_d  = lvl_q;
    rms_d  = rms_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      lvl_d  = level_i;
      rms_d  = rms_i;
      acc_d  = rlt_pkg::SmAccW'(rlt_pkg::RoundHalf);
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      acc_d  = total >> 1;
      lvl_d  = lvl_q >> 1;
      rms_d  = rms_q >> 1;
      step_d = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    rms_q <= rms_d;
    acc_q <= acc_d;
  end

  // the weights sum to one, so the result stays within 16 bits
  assign level_o = acc_q[rlt_pkg::LevelW-1:0];
  assign done_o  = done_q;

endmodule

// ===== hw/rtl/rms_level_trigger.sv =====
`timescale 1ns / 1ps

// RMS level follower with a one-shot threshold trigger.
// Input words arrive on s_axis: tdata carries a signed 16-bit sample, tlast
// marks the last sample of a buffer. Each sample is squared bit-serially and
// added to a saturating sum; samples beyond MAX_BUFFER in one buffer are dropped.
// On the tlast word the sum is divided by the sample count (one bit a cycle),
// its square root taken (one result bit a cycle), and the smoothed level updated
// (one operand bit a cycle). One output word then appears on m_axis: tdata holds
// the 16-bit level, tuser the trigger flag. Words without tlast give no output.
// A sample that is squared holds s_axis_tready low after acceptance until the
// 16-step squarer is done; a dropped sample without tlast leaves it high. A
// tlast word then runs the 29-step divider, 16-step root and 16-step smoother,
// after which the result is registered on m_axis and m_axis_tvalid rises.
// The output sits in a register: a new buffer is accepted while it waits, and
// only the next finished result waits in place when m_axis_tready is low.
// cfg_wr_en_i writes cfg_wr_data_i into the threshold; write it while idle.
// Reset clears sum, count, level and arms the trigger; threshold returns to 0.25.
module rms_level_trigger #(
  parameter int unsigned MAX_BUFFER = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,   // threshold
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // sample
  input  logic        s_axis_tlast,    // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // level
  output logic        m_axis_tuser     // trigger
);

  localparam int unsigned CntW = $clog2(MAX_BUFFER + 1);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_BUFFER);

  rlt_pkg::state_e state_q, state_d;

  logic [rlt_pkg::SumW-1:0]   sum_q, sum_d;
  logic [rlt_pkg::SumW:0]     sum_ext;
  logic [CntW-1:0]            count_q, count_d;
  logic                       last_q, last_d;
  logic [rlt_pkg::LevelW-1:0] level_q;
  logic                       fired_q;
  logic [rlt_pkg::LevelW-1:0] thr_q;
  logic                       m_valid_q, m_valid_d;
  logic [rlt_pkg::LevelW-1:0] m_level_q;
  logic                       m_trig_q;

  logic                       in_accept;
  logic                       emit_load;
  logic                       sq_start, div_start, root_start, sm_start;
  logic                       sq_done, div_done, root_done, sm_done;
  logic [rlt_pkg::SqW-1:0]    sq;
  logic [rlt_pkg::QuoW-1:0]   mean;
  logic [rlt_pkg::RootW-1:0]  rms;
  logic [rlt_pkg::LevelW-1:0] new_level;
  logic                       trig;
  logic                       fired_next;

  rlt_square u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sq_start),
    .sample_i (s_axis_tdata),
    .sq_o     (sq),
    .done_o   (sq_done)
  );

  rlt_divide #(
    .CntW (CntW)
  ) u_divide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .quo_o      (mean),
    .done_o     (div_done)
  );

  rlt_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .mean_i  (mean),
    .root_o  (rms),
    .done_o  (root_done)
  );

  rlt_smooth u_smooth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sm_start),
    .level_i (level_q),
    .rms_i   (rms),
    .level_o (new_level),
    .done_o  (sm_done)
  );

  assign s_axis_tready = (state_q == rlt_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign emit_load     = (state_q == rlt_pkg::S_EMIT) && (!m_valid_q || m_axis_tready);

  assign sum_ext    = {1'b0, sum_q} + (rlt_pkg::SumW + 1)'(sq);
  assign trig       = !fired_q && (new_level > thr_q);
  // fire first, then re-arm below the threshold
  assign fired_next = (fired_q || trig) && !(new_level < thr_q);

  always_comb begin
    state_d    = state_q;
    sum_d      = sum_q;
    count_d    = count_q;
    last_d     = last_q;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    sm_start   = 1'b0;
    case (state_q)
      rlt_pkg::S_IDLE: begin
        if (in_accept) begin
          last_d = s_axis_tlast;
          if (count_q < MaxCount) begin
            sq_start = 1'b1;
            state_d  = rlt_pkg::S_SQUARE;
          end else if (s_axis_tlast) begin
            state_d = rlt_pkg::S_LOAD;
          end
        end
      end
      rlt_pkg::S_SQUARE: begin
        if (sq_done) begin
          // saturate the running sum
          sum_d   = sum_ext[rlt_pkg::SumW] ? '1 : sum_ext[rlt_pkg::SumW-1:0];
          count_d = count_q + CntW'(1);
          state_d = last_q ? rlt_pkg::S_LOAD : rlt_pkg::S_IDLE;
        end
      end
      rlt_pkg::S_LOAD: begin
        div_start = 1'b1;
        state_d   = rlt_pkg::S_DIVIDE;
      end
      rlt_pkg::S_DIVIDE: begin
        if (div_done) begin
          root_start = 1'b1;
          state_d    = rlt_pkg::S_ROOT;
        end
      end
      rlt_pkg::S_ROOT: begin
        if (root_done) begin
          sm_start = 1'b1;
          state_d  = rlt_pkg::S_SMOOTH;
        end
      end
      rlt_pkg::S_SMOOTH: begin
        if (sm_done) begin
          state_d = rlt_pkg::S_EMIT;
        end
      end
      rlt_pkg::S_EMIT: begin
        if (emit_load) begin
          sum_d   = '0;
          count_d = '0;
          state_d = rlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rlt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (emit_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rlt_pkg::S_IDLE;
      sum_q     <= '0;
      count_q   <= '0;
      last_q    <= 1'b0;
      level_q   <= '0;
      fired_q   <= 1'b0;
      thr_q     <= rlt_pkg::ThresholdReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      last_q    <= last_d;
      m_valid_q <= m_valid_d;
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
      if (emit_load) begin
        level_q <= new_level;
        fired_q <= fired_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      m_level_q <= new_level;
      m_trig_q  <= trig;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_level_q;
  assign m_axis_tuser  = m_trig_q;

  a_clear_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> (sum_q == '0) && (count_q == '0))
    else $error("sum or count not cleared after result");

  a_trigger_sets_fired : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && trig) |=> fired_q)
    else $error("trigger did not disarm the unit");

  a_rearm_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && (new_level < thr_q)) |=> !fired_q)
    else $error("unit not re-armed below threshold");

  a_full_drops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (count_q == MaxCount)) |=> (count_q == MaxCount))
    else $error("sample counted beyond buffer limit");

endmodule

// ===== verif/tb_rms_level_trigger.sv =====
`timescale 1ns / 1ps

module tb_rms_level_trigger;

  localparam int unsigned MaxBuf = 256;
  localparam logic [36:0] SumMax = {37{1'b1}};

  typedef struct packed {
    logic [15:0] sample;
    logic        eob;
  } sample_word_t;

  typedef struct packed {
    logic [15:0] level;
    logic        trigger;
  } level_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic [15:0] cfg_wr_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  rms_level_trigger #(
    .MAX_BUFFER(MaxBuf)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // envelope follower state, mirrored
  logic [15:0]  threshold_q;
  logic [36:0]  square_sum;
  int unsigned  sample_cnt;
  logic [15:0]  level_q;
  logic         fired_q;

  sample_word_t pending_words[$];
  level_word_t  due_levels[$];
  sample_word_t drive_word;
  level_word_t  got_word;
  int unsigned  mismatches;
  int unsigned  src_gap;
  int unsigned  sink_gap;
  bit           bursts_on;

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  task automatic take_sample(input logic signed [15:0] smp, input logic eob);
    int          sv;
    logic [37:0] grown;
    logic [63:0] mean;
    logic [63:0] rms;
    logic [63:0] acc;
    level_word_t res;
    sv = smp;
    // drop samples once the buffer is full
    if (sample_cnt < MaxBuf) begin
      grown = {1'b0, square_sum} + 38'((32'(sv * sv)) >> 2);
      square_sum = (grown > {1'b0, SumMax}) ? SumMax : grown[36:0];
      sample_cnt++;
    end
    if (eob) begin
      mean = (sample_cnt != 0) ? 64'(square_sum) / 64'(sample_cnt) : 64'd0;
      rms = 64'(floor_root(mean << 2));
      acc = 64'(level_q) * 64'(rlt_pkg::WKeep) + rms * 64'(rlt_pkg::WNew)
          + 64'(rlt_pkg::RoundHalf);
      acc = acc >> 16;
      level_q = (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
      res.level = level_q;
      res.trigger = 1'b0;
      // rise first, then re-arm; equality does neither
      if (!fired_q && level_q > threshold_q) begin
        fired_q = 1'b1;
        res.trigger = 1'b1;
      end
      if (level_q < threshold_q) fired_q = 1'b0;
      square_sum = '0;
      sample_cnt = 0;
      due_levels = {due_levels, res};
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) take_sample(s_axis_tdata, s_axis_tlast);
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        drive_word = pending_words.pop_front();
        s_axis_tdata <= drive_word.sample;
        s_axis_tlast <= drive_word.eob;
        s_axis_tvalid <= 1'b1;
        if (bursts_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 13);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word: level %0d trigger %0b",
                     m_axis_tdata, m_axis_tuser);
        end else begin
          got_word = due_levels.pop_front();
          if (got_word.level !== m_axis_tdata || got_word.trigger !== m_axis_tuser) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output mismatch: expected level %0d trigger %0b, got level %0d trigger %0b",
                       got_word.level, got_word.trigger, m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (bursts_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 13);
      end
    end
  end

  function automatic int pick_sample(input int lo, input int hi);
    int m;
    m = int'($urandom_range(hi, lo));
    if ($urandom_range(0, 1)) m = -m;
    else if (m > 32767) m = 32767;
    return m;
  endfunction

  task automatic add_word(input int v, input logic eob);
    sample_word_t w;
    w.sample = v[15:0];
    w.eob = eob;
    pending_words = {pending_words, w};
  endtask

  task automatic add_buffer(input int len, input int lo, input int hi);
    for (int i = 0; i < len; i++) add_word(pick_sample(lo, hi), i == len - 1);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || due_levels.size() != 0)
      @(posedge clk_i);
  endtask

  // write only once the pipe is empty, leaving room for an open buffer's squarer
  task automatic write_threshold(input logic [15:0] thr);
    wait_drained();
    repeat (120) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= thr;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    threshold_q = thr;
  endtask

  initial begin
    int hold;
    logic [15:0] thr;
    rst_ni = 1'b0;
    cfg_wr_en_i <= 1'b0;
    cfg_wr_data_i <= '0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    threshold_q = rlt_pkg::ThresholdReset;
    square_sum = '0;
    sample_cnt = 0;
    level_q = '0;
    fired_q = 1'b0;
    mismatches = 0;
    src_gap = 0;
    sink_gap = 0;
    bursts_on = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full-scale extremes, one-sample buffers and mixed short buffers
    add_word(32767, 1'b1);
    add_word(-32768, 1'b1);
    add_word(0, 1'b1);
    add_word(-1, 1'b0);
    add_word(1, 1'b1);
    add_word(-32768, 1'b0);
    add_word(32767, 1'b0);
    add_word(-32768, 1'b0);
    add_word(16'h4000, 1'b1);
    add_word(16'h5555, 1'b0);
    add_word(-21846, 1'b1);

    // zero threshold: fire on any nonzero level, never re-arm
    write_threshold(16'd0);
    repeat (4) add_word(-32768, 1'b1);
    repeat (3) add_word(0, 1'b1);

    // top threshold: never fire, always re-arm
    write_threshold(16'hFFFF);
    repeat (3) add_word(32767, 1'b1);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: thr = 16'($urandom_range(0, 65535));
        1: thr = 16'($urandom_range(500, 12000));
        2: thr = level_q;
        default: thr = (p == 3) ? 16'd0 : 16'hFFFF;
      endcase
      write_threshold(thr);
      bursts_on = (p < 6) && (p != 2);
      if (p % 4 == 2) begin
        // hold the level exactly at the threshold
        hold = (level_q > 16'd32767) ? 32767 : int'(level_q);
        repeat (3) add_word(hold, 1'b1);
      end
      repeat ($urandom_range(2, 4)) add_buffer(1, 20000, 32768);
      repeat ($urandom_range(2, 3)) add_buffer($urandom_range(1, 2), 0, 400);
      repeat ($urandom_range(1, 2))
        add_buffer(($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6),
                   0, 32768);
      if (p == 1) add_buffer($urandom_range(MaxBuf + 1, MaxBuf + 8), 0, 32768);
      // leave a buffer open across the register write
      if (p % 4 != 1 && $urandom_range(0, 2) == 0) add_word(pick_sample(0, 32768), 1'b0);
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && due_levels.size() == 0) begin
      $display("rms_level_trigger test passed");
    end else begin
      $display("rms_level_trigger test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("rms_level_trigger test failed");
    $finish;
  end

endmodule
